// ===== design/llh_pkg.sv =====
package llh_pkg;

  // request opcodes on the input channel
  typedef enum logic [1:0] {
    OP_OBSERVE = 2'd0,
    OP_QUERY   = 2'd1,
    OP_SUMMARY = 2'd2,
    OP_CLEAR   = 2'd3
  } llh_op_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_OBS_RD,
    S_OBS_WR,
    S_TGT,
    S_WALK,
    S_LOAD
  } llh_state_t;

  // result kinds
  localparam logic KIND_PCT     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // percentile constants
  localparam logic [6:0] PCT_MEDIAN = 7'd50;
  localparam logic [6:0] PCT_P95    = 7'd95;
  localparam logic [6:0] PCT_P99    = 7'd99;
  localparam logic [6:0] PCT_MAX    = 7'd100;

  // target slots: 0 is the query or median, 2 is the last summary target
  localparam logic [1:0] TGT_MEDIAN = 2'd0;
  localparam logic [1:0] TGT_P95    = 2'd1;
  localparam logic [1:0] TGT_LAST   = 2'd2;

  // scaled compare width: 64-bit count times a 7-bit percentile
  localparam int SCW = 71;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       clear;
    logic       obs_rd;
    logic       obs_wr;
    logic       tgt_en;
    logic [1:0] tgt_sel;
    logic       walk_en;
    logic       load;
  } llh_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic is_sum;
    logic skip;
    logic walk_done;
    logic out_free;
  } llh_sts_t;

  // bit width of a value, 0 for zero, via per-byte encoders
  function automatic logic [6:0] width_of(input logic [63:0] v);
    logic [7:0]      nz;
    logic [7:0][3:0] bw;
    logic [6:0]      res;
    res = 7'd0;
    for (int j = 0; j < 8; j++) begin
      nz[j] = |v[8*j +: 8];
      bw[j] = 4'd0;
      for (int i = 0; i < 8; i++) begin
        if (v[8*j + i]) begin
          bw[j] = 4'(i + 1);
        end
      end
    end
    for (int j = 0; j < 8; j++) begin
      if (nz[j]) begin
        res = 7'(j * 8) + 7'(bw[j]);
      end
    end
    return res;
  endfunction

  // upper bound of a bucket: 2^b - 1, all ones for the top bucket
  function automatic logic [63:0] upper_of(input logic [6:0] b);
    logic [63:0] res;
    if (b >= 7'd64) begin
      res = '1;
    end else begin
      res = ~({64{1'b1}} << b[5:0]);
    end
    return res;
  endfunction

endpackage

// ===== design/log2_latency_histogram.sv =====
// channel  | handshake             | payload
// in_      | in_valid / in_ready   | in_cmd, in_duration, in_percentile
// out_     | out_valid / out_ready | out_kind, out_*_bound, out_sample_total_count,
//          |                       | out_duration_sum, out_smallest, out_largest
//
// one request at a time; clear acts as it is accepted, observe goes on to a bucket
// memory read then write; query and summary set their targets, one per slot, then the walk reads one
// bucket per cycle from the single memory read port through a 4-stage pipeline
// synchronous active-low reset empties the statistics through per-bucket valid bits
// a result waiting at the output does not block new requests, only the next result

module log2_latency_histogram #(
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_duration,
  input  logic [6:0]  in_percentile,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [63:0] out_percentile_bound,
  output logic [63:0] out_sample_total_count,
  output logic [63:0] out_duration_sum,
  output logic [63:0] out_smallest,
  output logic [63:0] out_largest,
  output logic [63:0] out_median_bound,
  output logic [63:0] out_p95_bound,
  output logic [63:0] out_p99_bound
);

  llh_pkg::llh_ctl_t ctl;
  llh_pkg::llh_sts_t sts;

  // sequencing
  llh_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_cmd  (in_cmd),
    .in_ready(in_ready),
    .sts     (sts),
    .ctl     (ctl)
  );

  // statistics, bucket store and percentile walk
  llh_dp #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_cmd                (in_cmd),
    .in_duration           (in_duration),
    .in_percentile         (in_percentile),
    .ctl                   (ctl),
    .sts                   (sts),
    .out_ready             (out_ready),
    .out_valid             (out_valid),
    .out_kind              (out_kind),
    .out_percentile_bound  (out_percentile_bound),
    .out_sample_total_count(out_sample_total_count),
    .out_duration_sum      (out_duration_sum),
    .out_smallest          (out_smallest),
    .out_largest           (out_largest),
    .out_median_bound      (out_median_bound),
    .out_p95_bound         (out_p95_bound),
    .out_p99_bound         (out_p99_bound)
  );

endmodule

// ===== design/llh_ram.sv =====
module llh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/llh_ctrl.sv =====
module llh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_cmd,
  output logic              in_ready,
  input  llh_pkg::llh_sts_t sts,
  output llh_pkg::llh_ctl_t ctl
);

  llh_pkg::llh_state_t state_r, state_nxt;
  logic [1:0]          k_r, k_nxt;
  llh_pkg::llh_op_t    op;

  assign op = llh_pkg::llh_op_t'(in_cmd);

  // state and target counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= llh_pkg::S_IDLE;
      k_r     <= llh_pkg::TGT_MEDIAN;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    k_nxt     = llh_pkg::TGT_MEDIAN;
    unique case (state_r)
      llh_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (op)
            llh_pkg::OP_OBSERVE: state_nxt = llh_pkg::S_OBS_RD;
            llh_pkg::OP_QUERY,
            llh_pkg::OP_SUMMARY: state_nxt = llh_pkg::S_TGT;
            llh_pkg::OP_CLEAR:   state_nxt = llh_pkg::S_IDLE;
            default:             state_nxt = llh_pkg::S_IDLE;
          endcase
        end
      end
      llh_pkg::S_OBS_RD: state_nxt = llh_pkg::S_OBS_WR;
      llh_pkg::S_OBS_WR: state_nxt = llh_pkg::S_IDLE;
      llh_pkg::S_TGT: begin
        if (sts.skip) begin
          state_nxt = llh_pkg::S_LOAD;
        end else if (!sts.is_sum || k_r == llh_pkg::TGT_LAST) begin
          state_nxt = llh_pkg::S_WALK;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      llh_pkg::S_WALK: begin
        if (sts.walk_done) begin
          state_nxt = llh_pkg::S_LOAD;
        end
      end
      llh_pkg::S_LOAD: begin
        if (sts.out_free) begin
          state_nxt = llh_pkg::S_IDLE;
        end
      end
      default: state_nxt = llh_pkg::S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    in_ready    = 1'b0;
    ctl         = '0;
    ctl.tgt_sel = k_r;
    unique case (state_r)
      llh_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
        ctl.clear   = in_valid && (op == llh_pkg::OP_CLEAR);
      end
      llh_pkg::S_OBS_RD: ctl.obs_rd = 1'b1;
      llh_pkg::S_OBS_WR: ctl.obs_wr = 1'b1;
      llh_pkg::S_TGT:    ctl.tgt_en = 1'b1;
      llh_pkg::S_WALK:   ctl.walk_en = 1'b1;
      llh_pkg::S_LOAD:   ctl.load = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== design/llh_dp.sv =====
module llh_dp #(
  parameter int VALUE_BITS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_cmd,
  input  logic [63:0]       in_duration,
  input  logic [6:0]        in_percentile,
  input  llh_pkg::llh_ctl_t ctl,
  output llh_pkg::llh_sts_t sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_kind,
  output logic [63:0]       out_percentile_bound,
  output logic [63:0]       out_sample_total_count,
  output logic [63:0]       out_duration_sum,
  output logic [63:0]       out_smallest,
  output logic [63:0]       out_largest,
  output logic [63:0]       out_median_bound,
  output logic [63:0]       out_p95_bound,
  output logic [63:0]       out_p99_bound
);

  localparam int NB  = VALUE_BITS + 1;
  localparam int AW  = $clog2(NB);
  localparam int ICW = $clog2(NB + 1);
  localparam int SCW = llh_pkg::SCW;
  localparam logic [64:0]    VMASK_W = (65'd1 << VALUE_BITS) - 65'd1;
  localparam logic [ICW-1:0] NB_C    = ICW'(NB);

  // captured request
  llh_pkg::llh_op_t op_r;
  logic [63:0]      d_r;
  logic [6:0]       pct_r;

  // summary statistics
  logic [63:0]   cnt_r, tot_r, min_r, max_r;
  logic [NB-1:0] vld_r;
  logic [AW-1:0] b_r;

  // walk pipeline
  logic [2:0][SCW-1:0] tgt_r;
  logic [2:0]          found_r;
  logic [2:0][63:0]    bnd_r;
  logic [ICW-1:0]      iss_r;
  logic                rv_r, mv_r, cv_r;
  logic [AW-1:0]       ridx_r, midx_r, cidx_r;
  logic [SCW-1:0]      m_r, cum_r;

  // output register
  logic        ov_r;
  logic        okind_r;
  logic [63:0] opb_r, ocnt_r, osum_r, omin_r, omax_r, omed_r, op95_r, op99_r;

  // ram port signals
  logic          ram_we;
  logic [AW-1:0] ram_ra;
  logic [63:0]   ram_wd, ram_rd;

  logic [6:0]     obs_b;
  logic [63:0]    obs_old, rd_eff;
  logic [64:0]    sum65;
  logic [6:0]     pm;
  logic [SCW-1:0] prod;
  logic           is_sum, skip, out_free;

  llh_ram #(
    .WIDTH(64),
    .DEPTH(NB)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(b_r),
    .wdata(ram_wd),
    .raddr(ram_ra),
    .rdata(ram_rd)
  );

  // observe: bucket index, saturating total
  assign obs_b   = llh_pkg::width_of(d_r);
  assign obs_old = vld_r[b_r] ? ram_rd : 64'd0;
  assign ram_wd  = obs_old + 64'd1;
  assign ram_we  = ctl.obs_wr && (cnt_r != '1);
  assign ram_ra  = ctl.obs_rd ? obs_b[AW-1:0] : iss_r[AW-1:0];
  assign sum65   = {1'b0, tot_r} + {1'b0, d_r};

  // status to the controller
  assign is_sum   = (op_r == llh_pkg::OP_SUMMARY);
  assign skip     = (cnt_r == 64'd0) ||
                    (!is_sum && (pct_r == 7'd0 || pct_r > llh_pkg::PCT_MAX));
  assign out_free = !ov_r || out_ready;
  assign sts.is_sum    = is_sum;
  assign sts.skip      = skip;
  assign sts.out_free  = out_free;
  assign sts.walk_done = (&found_r) || (iss_r == NB_C && !rv_r && !mv_r && !cv_r);

  // target percentile for the current slot
  always_comb begin
    case (ctl.tgt_sel)
      llh_pkg::TGT_MEDIAN: pm = is_sum ? llh_pkg::PCT_MEDIAN : pct_r;
      llh_pkg::TGT_P95:    pm = llh_pkg::PCT_P95;
      default:             pm = llh_pkg::PCT_P99;
    endcase
  end

  // count times percentile, compared against cumulative count times 100
  assign prod   = SCW'(cnt_r) * SCW'(pm);
  assign rd_eff = vld_r[ridx_r] ? ram_rd : 64'd0;

  // request capture
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_r  <= llh_pkg::llh_op_t'(in_cmd);
      d_r   <= in_duration & VMASK_W[63:0];
      pct_r <= in_percentile;
    end
    if (ctl.obs_rd) begin
      b_r <= obs_b[AW-1:0];
    end
  end

  // statistics and bucket valid bits
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      cnt_r <= 64'd0;
      tot_r <= 64'd0;
      min_r <= '1;
      max_r <= 64'd0;
      vld_r <= '0;
    end else if (ram_we) begin
      cnt_r      <= cnt_r + 64'd1;
      tot_r      <= sum65[64] ? '1 : sum65[63:0];
      vld_r[b_r] <= 1'b1;
      if (d_r < min_r) begin
        min_r <= d_r;
      end
      if (d_r > max_r) begin
        max_r <= d_r;
      end
    end
  end

  // walk control: issue, scale, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
      mv_r <= 1'b0;
      cv_r <= 1'b0;
    end else if (ctl.tgt_en) begin
      rv_r <= 1'b0;
      mv_r <= 1'b0;
      cv_r <= 1'b0;
    end else begin
      rv_r <= ctl.walk_en && (iss_r < NB_C);
      mv_r <= rv_r;
      cv_r <= mv_r;
    end
  end

  // walk data path
  always_ff @(posedge clk) begin
    if (ctl.tgt_en) begin
      tgt_r[ctl.tgt_sel] <= prod;
      iss_r   <= '0;
      cum_r   <= '0;
      found_r <= is_sum ? 3'b000 : 3'b110;
      bnd_r   <= {max_r, max_r, max_r};
    end else begin
      if (ctl.walk_en && iss_r < NB_C) begin
        iss_r  <= iss_r + ICW'(1);
        ridx_r <= iss_r[AW-1:0];
      end
      // bucket count times 100 as shifted adds
      if (rv_r) begin
        m_r    <= (SCW'(rd_eff) << 6) + (SCW'(rd_eff) << 5) + (SCW'(rd_eff) << 2);
        midx_r <= ridx_r;
      end
      if (mv_r) begin
        cum_r  <= cum_r + m_r;
        cidx_r <= midx_r;
      end
      // first bucket whose cumulative count reaches each rank
      if (cv_r) begin
        for (int j = 0; j < 3; j++) begin
          if (!found_r[j] && cum_r >= tgt_r[j]) begin
            found_r[j] <= 1'b1;
            bnd_r[j]   <= llh_pkg::upper_of(7'(cidx_r));
          end
        end
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ctl.load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      okind_r <= is_sum ? llh_pkg::KIND_SUMMARY : llh_pkg::KIND_PCT;
      opb_r   <= (skip || is_sum) ? 64'd0 : bnd_r[0];
      ocnt_r  <= (skip || !is_sum) ? 64'd0 : cnt_r;
      osum_r  <= (skip || !is_sum) ? 64'd0 : tot_r;
      omin_r  <= (skip || !is_sum) ? 64'd0 : min_r;
      omax_r  <= (skip || !is_sum) ? 64'd0 : max_r;
      omed_r  <= (skip || !is_sum) ? 64'd0 : bnd_r[0];
      op95_r  <= (skip || !is_sum) ? 64'd0 : bnd_r[1];
      op99_r  <= (skip || !is_sum) ? 64'd0 : bnd_r[2];
    end
  end

  assign out_valid              = ov_r;
  assign out_kind               = okind_r;
  assign out_percentile_bound   = opb_r;
  assign out_sample_total_count = ocnt_r;
  assign out_duration_sum       = osum_r;
  assign out_smallest           = omin_r;
  assign out_largest            = omax_r;
  assign out_median_bound       = omed_r;
  assign out_p95_bound          = op95_r;
  assign out_p99_bound          = op99_r;

endmodule

// ===== bench/log2_latency_histogram_tb.sv =====
module log2_latency_histogram_tb;

  localparam int          BUCKETS     = 65;
  localparam int          RANDOM_REQS = 2000;
  localparam int          IDLE_MAX    = 16;
  localparam int          DRAIN_WAIT  = 100;
  localparam logic [63:0] PCT_SCALE   = 64'd100;
  localparam logic [63:0] PCT_ROUND   = 64'd99;

  // one result as seen on the output channel
  typedef struct packed {
    logic        kind;
    logic [63:0] pct_bound;
    logic [63:0] count;
    logic [63:0] total;
    logic [63:0] low;
    logic [63:0] high;
    logic [63:0] p50;
    logic [63:0] p95;
    logic [63:0] p99;
  } hist_result_t;

  // shadow histogram and queue of awaited results
  class histogram_scoreboard;
    logic [63:0]  bucket_hits [BUCKETS];
    logic [63:0]  n_samples;
    logic [63:0]  dur_total;
    logic [63:0]  low_mark;
    logic [63:0]  high_mark;
    hist_result_t awaited [$];
    int           mismatches;
    int           results_seen;
    int           n_observe;
    int           n_query;
    int           n_summary;
    int           n_clear;
    int           n_saturated;
    int           n_top_bucket;

    function new();
      wipe();
      mismatches   = 0;
      results_seen = 0;
      n_observe    = 0;
      n_query      = 0;
      n_summary    = 0;
      n_clear      = 0;
      n_saturated  = 0;
      n_top_bucket = 0;
    endfunction

    function void wipe();
      foreach (bucket_hits[b]) bucket_hits[b] = '0;
      n_samples = '0;
      dur_total = '0;
      low_mark  = '1;
      high_mark = '0;
    endfunction

    // index of the highest set bit plus one, zero for zero
    function int msb_width(logic [63:0] v);
      int w;
      w = 0;
      for (int i = 0; i < 64; i++) begin
        if (v[i]) w = i + 1;
      end
      return w;
    endfunction

    function logic [63:0] bucket_top(int b);
      if (b >= 64) return '1;
      return (64'd1 << b) - 64'd1;
    endfunction

    // ceil(n * p / 100) split so the product cannot overflow, then cumulative walk
    function logic [63:0] rank_bound(logic [6:0] pct);
      logic [63:0] rank;
      logic [63:0] running;
      logic [63:0] p;
      p = 64'(pct);
      if (n_samples == 0 || p == 0 || p > PCT_SCALE) return '0;
      rank    = (n_samples / PCT_SCALE) * p +
                ((n_samples % PCT_SCALE) * p + PCT_ROUND) / PCT_SCALE;
      running = '0;
      for (int b = 0; b < BUCKETS; b++) begin
        running += bucket_hits[b];
        if (running >= rank) return bucket_top(b);
      end
      return high_mark;
    endfunction

    // update the shadow state for an accepted request
    function void note_request(llh_pkg::llh_op_t op, logic [63:0] dur, logic [6:0] pct);
      hist_result_t r;
      int           b;
      r = '0;
      case (op)
        llh_pkg::OP_OBSERVE: begin
          n_observe++;
          if (n_samples != '1) begin
            b = msb_width(dur);
            if (b == BUCKETS - 1) n_top_bucket++;
            bucket_hits[b] += 64'd1;
            n_samples      += 64'd1;
            if (dur < low_mark) low_mark = dur;
            if (dur > high_mark) high_mark = dur;
            if (dur <= ~dur_total) begin
              dur_total += dur;
            end else begin
              dur_total = '1;
              n_saturated++;
            end
          end
        end
        llh_pkg::OP_QUERY: begin
          n_query++;
          r.kind      = llh_pkg::KIND_PCT;
          r.pct_bound = rank_bound(pct);
          awaited.push_back(r);
        end
        llh_pkg::OP_SUMMARY: begin
          n_summary++;
          r.kind = llh_pkg::KIND_SUMMARY;
          if (n_samples != 0) begin
            r.count = n_samples;
            r.total = dur_total;
            r.low   = low_mark;
            r.high  = high_mark;
            r.p50   = rank_bound(llh_pkg::PCT_MEDIAN);
            r.p95   = rank_bound(llh_pkg::PCT_P95);
            r.p99   = rank_bound(llh_pkg::PCT_P99);
          end
          awaited.push_back(r);
        end
        default: begin
          n_clear++;
          wipe();
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("result %0d %s got %h want %h", results_seen, name, got, want));
      end
    endtask

    // compare one result against the oldest awaited one
    task check_result(hist_result_t got);
      hist_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing awaited", results_seen));
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind) begin
        report_mismatch($sformatf("result %0d kind got %b want %b", results_seen, got.kind,
                                  want.kind));
      end
      compare_field("percentile_bound", got.pct_bound, want.pct_bound);
      compare_field("sample_total_count", got.count, want.count);
      compare_field("duration_sum", got.total, want.total);
      compare_field("smallest", got.low, want.low);
      compare_field("largest", got.high, want.high);
      compare_field("median_bound", got.p50, want.p50);
      compare_field("p95_bound", got.p95, want.p95);
      compare_field("p99_bound", got.p99, want.p99);
    endtask
  endclass

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd        = llh_pkg::OP_OBSERVE;
  logic [63:0] in_duration   = '0;
  logic [6:0]  in_percentile = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic        out_kind;
  logic [63:0] out_percentile_bound;
  logic [63:0] out_sample_total_count;
  logic [63:0] out_duration_sum;
  logic [63:0] out_smallest;
  logic [63:0] out_largest;
  logic [63:0] out_median_bound;
  logic [63:0] out_p95_bound;
  logic [63:0] out_p99_bound;

  histogram_scoreboard sb;
  logic                tx_burst = 1'b0;
  logic                rx_burst = 1'b0;

  log2_latency_histogram dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_cmd                 (in_cmd),
    .in_duration            (in_duration),
    .in_percentile          (in_percentile),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_kind               (out_kind),
    .out_percentile_bound   (out_percentile_bound),
    .out_sample_total_count (out_sample_total_count),
    .out_duration_sum       (out_duration_sum),
    .out_smallest           (out_smallest),
    .out_largest            (out_largest),
    .out_median_bound       (out_median_bound),
    .out_p95_bound          (out_p95_bound),
    .out_p99_bound          (out_p99_bound)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // drive one request, holding valid across back-to-back requests
  task automatic send_request(llh_pkg::llh_op_t op, logic [63:0] dur, logic [6:0] pct);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_burst = ~tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= op;
    in_duration   <= dur;
    in_percentile <= pct;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, dur, pct);
  endtask

  // hold off new requests until every awaited result is back
  task automatic drain_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // accept results with random stalls
  task automatic collect_results();
    int           gap;
    hist_result_t got;
    forever begin
      if ($urandom_range(0, 49) == 0) rx_burst = ~rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.kind      = out_kind;
      got.pct_bound = out_percentile_bound;
      got.count     = out_sample_total_count;
      got.total     = out_duration_sum;
      got.low       = out_smallest;
      got.high      = out_largest;
      got.p50       = out_median_bound;
      got.p95       = out_p95_bound;
      got.p99       = out_p99_bound;
      sb.check_result(got);
    end
  endtask

  // duration spread over all buckets, with some fully random and huge values
  function automatic logic [63:0] pick_duration();
    int          w;
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return v;
      1: return v | 64'h8000_0000_0000_0000;
      default: begin
        w = $urandom_range(0, 64);
        if (w == 0) return '0;
        if (w < 64) v = v & ((64'd1 << w) - 64'd1);
        return v | (64'd1 << (w - 1));
      end
    endcase
  endfunction

  function automatic logic [6:0] pick_percentile();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 7'($urandom_range(1, 100));
    if (r == 6) return llh_pkg::PCT_MEDIAN;
    if (r == 7) return ($urandom_range(0, 1) != 0) ? llh_pkg::PCT_P99 : llh_pkg::PCT_MAX;
    return 7'($urandom_range(0, 127));
  endfunction

  // edge values, empty store, bad percentiles, total overflow and clear
  task automatic run_directed();
    send_request(llh_pkg::OP_SUMMARY, '0, '0);
    send_request(llh_pkg::OP_QUERY, '0, llh_pkg::PCT_MEDIAN);
    send_request(llh_pkg::OP_QUERY, '1, 7'd0);
    send_request(llh_pkg::OP_OBSERVE, 64'd0, '1);
    send_request(llh_pkg::OP_OBSERVE, 64'd1, '0);
    send_request(llh_pkg::OP_OBSERVE, '1, '0);
    send_request(llh_pkg::OP_OBSERVE, 64'h8000_0000_0000_0000, '0);
    send_request(llh_pkg::OP_QUERY, '0, 7'd1);
    send_request(llh_pkg::OP_QUERY, '0, llh_pkg::PCT_MEDIAN);
    send_request(llh_pkg::OP_QUERY, '0, llh_pkg::PCT_MAX);
    send_request(llh_pkg::OP_QUERY, '0, 7'd101);
    send_request(llh_pkg::OP_QUERY, '0, 7'd127);
    send_request(llh_pkg::OP_SUMMARY, '1, '1);
    send_request(llh_pkg::OP_CLEAR, '1, '1);
    send_request(llh_pkg::OP_SUMMARY, '0, llh_pkg::PCT_P95);
    send_request(llh_pkg::OP_OBSERVE, 64'd3, '0);
    send_request(llh_pkg::OP_OBSERVE, 64'd1000, '0);
    send_request(llh_pkg::OP_OBSERVE, 64'd7, '0);
    send_request(llh_pkg::OP_QUERY, '0, llh_pkg::PCT_P99);
    send_request(llh_pkg::OP_QUERY, '0, 7'd34);
    send_request(llh_pkg::OP_SUMMARY, '0, '0);
    send_request(llh_pkg::OP_CLEAR, '0, '0);
  endtask

  // random traffic: mostly observations so the histogram fills up
  task automatic run_random();
    int r;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 2) drain_pause();
      r = $urandom_range(0, 99);
      if (r < 68) begin
        send_request(llh_pkg::OP_OBSERVE, pick_duration(), 7'($urandom_range(0, 127)));
      end else if (r < 86) begin
        send_request(llh_pkg::OP_QUERY, {$urandom, $urandom}, pick_percentile());
      end else if (r < 98) begin
        send_request(llh_pkg::OP_SUMMARY, {$urandom, $urandom},
                     7'($urandom_range(0, 127)));
      end else begin
        send_request(llh_pkg::OP_CLEAR, {$urandom, $urandom}, 7'($urandom_range(0, 127)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    fork
      collect_results();
    join_none
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.awaited.size() != 0) sb.report_mismatch("results still awaited at end of run");
    $display("covered %0d observe, %0d query, %0d summary and %0d clear requests",
             sb.n_observe, sb.n_query, sb.n_summary, sb.n_clear);
    $display("checked %0d results; total saturated %0d times, top bucket hit %0d times",
             sb.results_seen, sb.n_saturated, sb.n_top_bucket);
    if (sb.mismatches == 0) begin
      $display("log2_latency_histogram_tb: clean");
    end else begin
      $display("log2_latency_histogram_tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout waiting for the block");
    $display("log2_latency_histogram_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/llh_pkg.sv
design/llh_ram.sv
design/llh_ctrl.sv
design/llh_dp.sv
design/log2_latency_histogram.sv
bench/log2_latency_histogram_tb.sv
